/* rtl/cesc_pkg.sv */
// ----------------------------------------------------------------------------
// cesc_pkg: shared types and helpers for the C escape unescaper
// Result record, decoder-to-buffer push bundle, character constants and
// small lookup functions for escape letters and hex digits.
// ----------------------------------------------------------------------------
package cesc_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LOWER   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;
    localparam logic [7:0] CH_F_LOWER   = 8'h66;
    localparam logic [7:0] CH_A_UPPER   = 8'h41;
    localparam logic [7:0] CH_F_UPPER   = 8'h46;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       end_of_string;
        logic       bad_escape;
    } result_t;

    // Up to two results per input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // {hit, byte} for a simple escape letter
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            "n":          r = {1'b1, 8'd10};
            "t":          r = {1'b1, 8'd9};
            "v":          r = {1'b1, 8'd11};
            "b":          r = {1'b1, 8'd8};
            "r":          r = {1'b1, 8'd13};
            "f":          r = {1'b1, 8'd12};
            "a":          r = {1'b1, 8'd7};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            "?":          r = {1'b1, 8'd63};
            "'":          r = {1'b1, 8'd39};
            "\"":         r = {1'b1, 8'd34};
            default:      r = 9'd0;
        endcase
        return r;
    endfunction

    // {hit, nibble} for a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        r = 5'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
            r = {1'b1, d[3:0]};
        end else if (c inside {[CH_A_LOWER:CH_F_LOWER]}) begin
            d = c - CH_A_LOWER + 8'd10;
            r = {1'b1, d[3:0]};
        end else if (c inside {[CH_A_UPPER:CH_F_UPPER]}) begin
            d = c - CH_A_UPPER + 8'd10;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_SEVEN]});
    endfunction

endpackage

/* rtl/cesc_in_if.sv */
// ----------------------------------------------------------------------------
// cesc_in_if: escaped byte stream channel
// valid/ready channel carrying one escaped byte and its end-of-string flag.
// ----------------------------------------------------------------------------
interface cesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       string_end;

    modport source (output valid, output char_in, output string_end, input ready);
    modport sink   (input valid, input char_in, input string_end, output ready);
endinterface

/* rtl/cesc_out_if.sv */
// ----------------------------------------------------------------------------
// cesc_out_if: decoded byte stream channel
// valid/ready channel carrying one decoded result.
// ----------------------------------------------------------------------------
interface cesc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic       end_of_string;
    logic       bad_escape;

    modport source (output valid, output char_out, output char_valid,
                    output end_of_string, output bad_escape, input ready);
    modport sink   (input valid, input char_out, input char_valid,
                    input end_of_string, input bad_escape, output ready);
endinterface

/* rtl/cesc_decoder.sv */
// ----------------------------------------------------------------------------
// cesc_decoder: per-byte escape state machine
// Holds the escape phase, gathered digits and sticky error; decodes the
// current byte into zero, one or two results in the same cycle.
// ----------------------------------------------------------------------------
module cesc_decoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      char_in,
    input  logic            string_end,
    output cesc_pkg::push_t push
);

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_OCT1,
        PH_OCT2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] partial_reg, partial_next;
    logic       failed_reg, failed_next;

    cesc_pkg::result_t slot [2];
    logic [1:0]        cnt;
    logic [8:0]        esc;
    logic [4:0]        hex;
    logic              oct;
    logic [7:0]        digit;
    logic [7:0]        oct_val;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        failed_next  = failed_reg;
        slot[0]      = '0;
        slot[1]      = '0;
        cnt          = 2'd0;
        esc          = cesc_pkg::simple_escape(char_in);
        hex          = cesc_pkg::hex_value(char_in);
        oct          = cesc_pkg::is_octal(char_in);
        digit        = char_in - cesc_pkg::CH_ZERO;
        oct_val      = {partial_reg[4:0], digit[2:0]};

        case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_TEXT;
                if (esc[8])
                begin
                    slot[cnt[0]].char_out   = esc[7:0];
                    slot[cnt[0]].char_valid = 1'b1;
                    cnt = cnt + 2'd1;
                end
                else if (char_in == cesc_pkg::CH_X_LOWER)
                begin
                    phase_next = PH_HEX1;
                end
                else if (oct)
                begin
                    partial_next = {5'd0, digit[2:0]};
                    phase_next   = PH_OCT1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            PH_HEX1:
            begin
                if (hex[4])
                begin
                    partial_next = {4'd0, hex[3:0]};
                    phase_next   = PH_HEX2;
                end
                else
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_TEXT;
                end
            end
            PH_HEX2:
            begin
                if (hex[4])
                begin
                    slot[cnt[0]].char_out   = {partial_reg[3:0], hex[3:0]};
                    slot[cnt[0]].char_valid = 1'b1;
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
                phase_next = PH_TEXT;
            end
            PH_OCT1, PH_OCT2:
            begin
                if (oct)
                begin
                    partial_next = oct_val;
                    if (phase_reg == PH_OCT1)
                    begin
                        phase_next = PH_OCT2;
                    end
                    else
                    begin
                        slot[cnt[0]].char_out   = oct_val;
                        slot[cnt[0]].char_valid = 1'b1;
                        cnt = cnt + 2'd1;
                        phase_next = PH_TEXT;
                    end
                end
                else
                begin
                    // short octal goes out first, then the byte is plain text
                    slot[cnt[0]].char_out   = partial_reg;
                    slot[cnt[0]].char_valid = 1'b1;
                    cnt = cnt + 2'd1;
                    phase_next = PH_TEXT;
                    if (char_in == cesc_pkg::CH_BACKSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        slot[cnt[0]].char_out   = char_in;
                        slot[cnt[0]].char_valid = 1'b1;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_TEXT;
                if (char_in == cesc_pkg::CH_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    slot[cnt[0]].char_out   = char_in;
                    slot[cnt[0]].char_valid = 1'b1;
                    cnt = cnt + 2'd1;
                end
            end
        endcase

        if (string_end)
        begin
            if (phase_next == PH_OCT1 || phase_next == PH_OCT2)
            begin
                slot[cnt[0]].char_out   = partial_next;
                slot[cnt[0]].char_valid = 1'b1;
                cnt = cnt + 2'd1;
            end
            else if (phase_next != PH_TEXT)
            begin
                failed_next = 1'b1;
            end
            if (cnt == 2'd0)
            begin
                cnt = 2'd1;
            end
            // closing result is the last one filled
            slot[cnt[1]].end_of_string = 1'b1;
            slot[cnt[1]].bad_escape    = failed_next;
            phase_next   = PH_TEXT;
            partial_next = 8'd0;
            failed_next  = 1'b0;
        end
    end

    assign push.count  = cnt;
    assign push.first  = slot[0];
    assign push.second = slot[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TEXT;
            partial_reg <= 8'd0;
            failed_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

/* rtl/c_escape_unescaper.sv */
// ----------------------------------------------------------------------------
// c_escape_unescaper: C escape sequence decoder, one byte per cycle unless stalled
// Decodes a byte stream with C escapes into plain bytes, one string at a time.
// ----------------------------------------------------------------------------
// Usage: feed escaped bytes on esc_stream, flagging the last byte of each
// string with string_end; decoded bytes leave on plain_stream. The block
// takes one byte per clock unless stalled. A byte is decoded in the cycle
// of its transfer and yields zero, one or two results (two only when a
// short octal escape is ended by a plain byte); results go into an output
// queue of DEPTH entries and appear on plain_stream from the next cycle on,
// one per cycle unless stalled. esc_stream.ready is high while the queue
// has room for two results, so with the output taking every cycle the input
// stalls only once two-result bytes outnumber bytes that decode to nothing
// by DEPTH - 2 since the queue last ran empty; each two-result byte costs
// an extra output transfer. Every string closes with exactly one result
// that has end_of_string set; it carries bad_escape if any escape in the
// string was malformed (unknown letter, bad or missing hex digit, trailing
// backslash), and has char_valid clear with char_out zero when that byte
// decoded to nothing. Error and escape state are cleared after each string.
// ----------------------------------------------------------------------------
module c_escape_unescaper #(
    parameter int DEPTH = cesc_pkg::FIFO_DEPTH   // output queue entries, >= 2
) (
    input  logic   clk,
    input  logic   rst_n,
    cesc_in_if.sink    esc_stream,
    cesc_out_if.source plain_stream
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cesc_pkg::push_t   push;
    cesc_pkg::result_t fifo_reg [DEPTH];
    cesc_pkg::result_t head;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;
    logic             pop;
    logic [1:0]       push_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // decoder only advances on an input transfer
    cesc_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .char_in    (esc_stream.char_in),
        .string_end (esc_stream.string_end),
        .push       (push)
    );

    // room for the worst case of two results, independent of output ready
    assign esc_stream.ready = (count_reg <= CNT_W'(DEPTH - 2));
    assign accept           = esc_stream.valid && esc_stream.ready;
    assign push_cnt         = accept ? push.count : 2'd0;

    assign plain_stream.valid = (count_reg != '0);
    assign pop                = plain_stream.valid && plain_stream.ready;

    assign head                       = fifo_reg[rd_ptr_reg];
    assign plain_stream.char_out      = head.char_out;
    assign plain_stream.char_valid    = head.char_valid;
    assign plain_stream.end_of_string = head.end_of_string;
    assign plain_stream.bad_escape    = head.bad_escape;

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= push.first;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

/* rtl/cesc_checker.sv */
// ----------------------------------------------------------------------------
// cesc_checker: port-level checks for the C escape unescaper
// Watches both channels and checks ordering of string closes and stalls.
// ----------------------------------------------------------------------------
module cesc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_string_end,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char_out,
    input logic       out_char_valid,
    input logic       out_end_of_string
);

    logic [7:0] open_reg;
    logic       end_in;
    logic       end_out;

    assign end_in  = in_valid && in_ready && in_string_end;
    assign end_out = out_valid && out_ready && out_end_of_string;

    // strings closed on input but not yet on output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 8'd0;
        end
        else
        begin
            open_reg <= open_reg + {7'd0, end_in} - {7'd0, end_out};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped during stall");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output queue");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_char_valid |-> out_end_of_string && out_char_out == 8'd0)
        else $error("result without byte is not a clean string close");

    a_close_order: assert property (@(posedge clk) disable iff (!rst_n)
        end_out |-> open_reg != 8'd0)
        else $error("string closed on output before its last byte was taken");

endmodule

bind c_escape_unescaper cesc_checker u_cesc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (esc_stream.valid),
    .in_ready          (esc_stream.ready),
    .in_string_end     (esc_stream.string_end),
    .out_valid         (plain_stream.valid),
    .out_ready         (plain_stream.ready),
    .out_char_out      (plain_stream.char_out),
    .out_char_valid    (plain_stream.char_valid),
    .out_end_of_string (plain_stream.end_of_string)
);

/* sim/c_escape_unescaper_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_unescaper_checker: decoded-stream scoreboard
// Watches both channels of the unescaper, decodes each accepted input byte
// with its own escape decoder and compares every output transfer with the
// oldest decoded result still owed.
// ----------------------------------------------------------------------------
module c_escape_unescaper_checker (
    input  logic clk,
    input  logic rst_n,
    cesc_in_if   esc_stream,
    cesc_out_if  plain_stream,
    output int   fail_count,
    output int   pending
);

    typedef enum logic [2:0] {
        SEQ_TEXT,
        SEQ_ESC,
        SEQ_HEX_HI,
        SEQ_HEX_LO,
        SEQ_OCT_ONE,
        SEQ_OCT_TWO
    } seq_phase_t;

    seq_phase_t          seq_phase;
    logic [7:0]          digit_acc;
    logic                err_seen;
    cesc_pkg::result_t   owed_q[$];

    // byte for a simple escape letter, -1 if the letter is not one
    function automatic int letter_byte(input logic [7:0] c);
        case (c)
            "n":                    return 10;
            "t":                    return 9;
            "v":                    return 11;
            "b":                    return 8;
            "r":                    return 13;
            "f":                    return 12;
            "a":                    return 7;
            cesc_pkg::CH_BACKSLASH: return 92;
            "?":                    return 63;
            "'":                    return 39;
            "\"":                   return 34;
            default:                return -1;
        endcase
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c inside {[cesc_pkg::CH_ZERO:cesc_pkg::CH_NINE]})
            return int'(c - cesc_pkg::CH_ZERO);
        if (c inside {[cesc_pkg::CH_A_LOWER:cesc_pkg::CH_F_LOWER]})
            return int'(c - cesc_pkg::CH_A_LOWER) + 10;
        if (c inside {[cesc_pkg::CH_A_UPPER:cesc_pkg::CH_F_UPPER]})
            return int'(c - cesc_pkg::CH_A_UPPER) + 10;
        return -1;
    endfunction

    function automatic logic octal_digit(input logic [7:0] c);
        return (c inside {[cesc_pkg::CH_ZERO:cesc_pkg::CH_SEVEN]});
    endfunction

    function automatic void owe_byte(input logic [7:0] ch, input logic valid);
        cesc_pkg::result_t r;
        r.char_out      = valid ? ch : 8'd0;
        r.char_valid    = valid;
        r.end_of_string = 1'b0;
        r.bad_escape    = 1'b0;
        owed_q.push_back(r);
    endfunction

    function automatic void text_char(input logic [7:0] c);
        if (c == cesc_pkg::CH_BACKSLASH)
            seq_phase = SEQ_ESC;
        else
            owe_byte(c, 1'b1);
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic last);
        int                v;
        int                n0;
        cesc_pkg::result_t r;
        n0 = owed_q.size();
        case (seq_phase)
            SEQ_ESC:
            begin
                v = letter_byte(c);
                seq_phase = SEQ_TEXT;
                if (v >= 0)
                    owe_byte(v[7:0], 1'b1);
                else if (c == cesc_pkg::CH_X_LOWER)
                    seq_phase = SEQ_HEX_HI;
                else if (octal_digit(c))
                begin
                    digit_acc = {5'd0, c[2:0]};
                    seq_phase = SEQ_OCT_ONE;
                end
                else
                    err_seen = 1'b1;
            end
            SEQ_HEX_HI:
            begin
                v = hex_nibble(c);
                if (v >= 0)
                begin
                    digit_acc = {4'd0, v[3:0]};
                    seq_phase = SEQ_HEX_LO;
                end
                else
                begin
                    err_seen  = 1'b1;
                    seq_phase = SEQ_TEXT;
                end
            end
            SEQ_HEX_LO:
            begin
                v = hex_nibble(c);
                if (v >= 0)
                    owe_byte({digit_acc[3:0], v[3:0]}, 1'b1);
                else
                    err_seen = 1'b1;
                seq_phase = SEQ_TEXT;
            end
            SEQ_OCT_ONE, SEQ_OCT_TWO:
            begin
                if (octal_digit(c))
                begin
                    digit_acc = {digit_acc[4:0], c[2:0]};
                    if (seq_phase == SEQ_OCT_ONE)
                        seq_phase = SEQ_OCT_TWO;
                    else
                    begin
                        owe_byte(digit_acc, 1'b1);
                        seq_phase = SEQ_TEXT;
                    end
                end
                else
                begin
                    // short octal value goes out ahead of the byte that ends it
                    owe_byte(digit_acc, 1'b1);
                    seq_phase = SEQ_TEXT;
                    text_char(c);
                end
            end
            default:
            begin
                seq_phase = SEQ_TEXT;
                text_char(c);
            end
        endcase

        if (last)
        begin
            if (seq_phase == SEQ_OCT_ONE || seq_phase == SEQ_OCT_TWO)
                owe_byte(digit_acc, 1'b1);
            else if (seq_phase != SEQ_TEXT)
                err_seen = 1'b1;
            if (owed_q.size() == n0)
                owe_byte(8'd0, 1'b0);
            r = owed_q.pop_back();
            r.end_of_string = 1'b1;
            r.bad_escape    = err_seen;
            owed_q.push_back(r);
            seq_phase = SEQ_TEXT;
            digit_acc = 8'd0;
            err_seen  = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cesc_pkg::result_t got;
        cesc_pkg::result_t want;
        if (!rst_n)
        begin
            seq_phase = SEQ_TEXT;
            digit_acc = 8'd0;
            err_seen  = 1'b0;
            owed_q.delete();
            pending <= 0;
        end
        else
        begin
            if (plain_stream.valid === 1'b1 && plain_stream.ready === 1'b1)
            begin
                got.char_out      = plain_stream.char_out;
                got.char_valid    = plain_stream.char_valid;
                got.end_of_string = plain_stream.end_of_string;
                got.bad_escape    = plain_stream.bad_escape;
                if (owed_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%t unexpected: out=%02h valid=%b eos=%b bad=%b",
                                 $time, got.char_out, got.char_valid,
                                 got.end_of_string, got.bad_escape);
                    fail_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.char_out !== want.char_out || got.char_valid !== want.char_valid ||
                        got.end_of_string !== want.end_of_string ||
                        got.bad_escape !== want.bad_escape)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%t mismatch exp: out=%02h valid=%b eos=%b bad=%b",
                                     $time, want.char_out, want.char_valid,
                                     want.end_of_string, want.bad_escape);
                            $display("%t          got: out=%02h valid=%b eos=%b bad=%b",
                                     $time, got.char_out, got.char_valid,
                                     got.end_of_string, got.bad_escape);
                        end
                        fail_count++;
                    end
                end
            end
            if (esc_stream.valid === 1'b1 && esc_stream.ready === 1'b1)
                decode_byte(esc_stream.char_in, esc_stream.string_end);
            pending <= owed_q.size();
        end
    end

endmodule

/* sim/c_escape_unescaper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_unescaper_tb: regression bench for the C escape unescaper
// Feeds directed escape strings, then random strings built mostly from
// well-formed escapes with broken and truncated sequences mixed in, over
// phases of sender idling and receiver stalling. The checker beside the
// block predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module c_escape_unescaper_tb;

    localparam int CYCLE_LIMIT  = 500000;  // far beyond the slowest correct run
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASE_COUNT  = 8;
    localparam int DRAIN_CYCLES = 20;      // queue depth plus margin

    logic clk = 1'b0;
    logic rst_n;

    int idle_pct;      // chance per cycle that the sender holds off
    int stall_pct;     // chance per cycle that the receiver drops ready
    int fail_count;
    int pending;       // decoded results still owed, from the checker
    int sent_bytes;
    int cycle_count;

    logic [7:0] str_q[$];   // string being assembled for sending

    cesc_in_if  esc_if();
    cesc_out_if plain_if();

    c_escape_unescaper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .esc_stream   (esc_if),
        .plain_stream (plain_if)
    );

    c_escape_unescaper_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .esc_stream   (esc_if),
        .plain_stream (plain_if),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    // Receiver: ready is redrawn every cycle from the current stall rate.
    initial
    begin
        plain_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            plain_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("c_escape_unescaper regression: fail");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(10))
            0:       return "n";
            1:       return "t";
            2:       return "v";
            3:       return "b";
            4:       return "r";
            5:       return "f";
            6:       return "a";
            7:       return cesc_pkg::CH_BACKSLASH;
            8:       return "?";
            9:       return "'";
            default: return "\"";
        endcase
    endfunction

    // hex digit in either case
    function automatic logic [7:0] pick_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return cesc_pkg::CH_ZERO + v[7:0];
        if ($urandom_range(1))
            return cesc_pkg::CH_A_UPPER + v[7:0] - 8'd10;
        return cesc_pkg::CH_A_LOWER + v[7:0] - 8'd10;
    endfunction

    function automatic logic [7:0] pick_octal();
        return cesc_pkg::CH_ZERO + 8'($urandom_range(7));
    endfunction

    task automatic load_text(input string s);
        foreach (s[i])
            str_q.push_back(s[i]);
    endtask

    // One escape-string fragment. Mostly well formed; the rest are bad
    // letters, bad hex digits and raw noise bytes.
    task automatic add_piece();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 35)
            str_q.push_back(rand_byte());
        else if (kind < 55)
        begin
            str_q.push_back(cesc_pkg::CH_BACKSLASH);
            str_q.push_back(pick_letter());
        end
        else if (kind < 70)
        begin
            str_q.push_back(cesc_pkg::CH_BACKSLASH);
            str_q.push_back(cesc_pkg::CH_X_LOWER);
            str_q.push_back(pick_hex());
            str_q.push_back(pick_hex());
        end
        else if (kind < 85)
        begin
            // short forms may get extended or ended by whatever follows
            n = $urandom_range(1, 3);
            str_q.push_back(cesc_pkg::CH_BACKSLASH);
            repeat (n)
                str_q.push_back(pick_octal());
        end
        else
        begin
            str_q.push_back(cesc_pkg::CH_BACKSLASH);
            case ($urandom_range(2))
                0:
                    str_q.push_back(rand_byte());
                1:
                begin
                    str_q.push_back(cesc_pkg::CH_X_LOWER);
                    str_q.push_back(rand_byte());
                end
                default:
                begin
                    str_q.push_back(cesc_pkg::CH_X_LOWER);
                    str_q.push_back(pick_hex());
                    str_q.push_back(rand_byte());
                end
            endcase
        end
    endtask

    // String cut off inside an escape: trailing backslash, unfinished hex,
    // or a pending octal value that the closing byte has to flush.
    task automatic add_open_escape();
        str_q.push_back(cesc_pkg::CH_BACKSLASH);
        case ($urandom_range(4))
            0: ;
            1: str_q.push_back(cesc_pkg::CH_X_LOWER);
            2:
            begin
                str_q.push_back(cesc_pkg::CH_X_LOWER);
                str_q.push_back(pick_hex());
            end
            3: str_q.push_back(pick_octal());
            default:
            begin
                str_q.push_back(pick_octal());
                str_q.push_back(pick_octal());
            end
        endcase
    endtask

    task automatic build_string();
        int n;
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        repeat (n)
            add_piece();
        if ($urandom_range(99) < 15)
            add_open_escape();
        if (str_q.size() == 0)
            str_q.push_back(rand_byte());
    endtask

    // One byte transfer. Idle cycles scramble the payload so that a block
    // which samples without valid gets caught. valid is only written once
    // per clock edge.
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            esc_if.valid      <= 1'b0;
            esc_if.char_in    <= rand_byte();
            esc_if.string_end <= 1'($urandom_range(1));
            @(posedge clk);
        end
        esc_if.valid      <= 1'b1;
        esc_if.char_in    <= c;
        esc_if.string_end <= last;
        @(posedge clk);
        while (esc_if.ready !== 1'b1)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Send the assembled string, end flag on its final byte.
    task automatic send_string();
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    // Sender pauses until every owed result has been transferred. The first
    // edge lets the checker's count catch up with the last transfer.
    task automatic wait_drained();
        esc_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int p;
        int phase_start;
        esc_if.valid      = 1'b0;
        esc_if.char_in    = 8'd0;
        esc_if.string_end = 1'b0;
        rst_n      = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        sent_bytes = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings, full rate.
        str_q.push_back(8'h00);                         // zero byte as text
        send_string();
        str_q.push_back(8'hFF);
        send_string();
        load_text("\\n");
        send_string();
        str_q.push_back(cesc_pkg::CH_BACKSLASH);        // zero after backslash
        str_q.push_back(8'h00);
        send_string();
        load_text("\\x7f");
        send_string();
        load_text("\\xZ");                              // bad first hex digit
        send_string();
        load_text("\\777");                             // octal wraps to 8 bits
        send_string();
        load_text("\\7A");                              // short octal, then text
        send_string();
        load_text("\\");                                // trailing backslash
        send_string();
        load_text("\\x4");                              // hex cut off at the end
        send_string();
        load_text("\\12");                              // octal flushed at the end
        send_string();
        wait_drained();

        // Random strings over the idle/stall mixes, draining between phases.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < RANDOM_ITEMS / PHASE_COUNT)
            begin
                build_string();
                send_string();
            end
            wait_drained();
        end

        // Anything the block still emits now is unexpected.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("c_escape_unescaper regression: pass");
        else
            $display("c_escape_unescaper regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/cesc_pkg.sv
rtl/cesc_in_if.sv
rtl/cesc_out_if.sv
rtl/cesc_decoder.sv
rtl/c_escape_unescaper.sv
rtl/cesc_checker.sv
sim/c_escape_unescaper_checker.sv
sim/c_escape_unescaper_tb.sv
